/* rtl/msg_pkg.sv */
// shared types and constants for the multi-stop colour gradient core
// no dependencies; imported by every module of the block
`default_nettype none

package msg_pkg;

    localparam int MAX_SEGMENT_DEF = 1024;
    localparam int NUM_STOPS_DEF   = 5;
    localparam int PIPE_STAGES     = 12;

    localparam int OFF_W      = 10;
    localparam int POS_W      = 16;
    localparam int CHAN_W     = 8;
    localparam int CNT_W      = 3;
    localparam int LEN_REG_W  = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    localparam logic [CHAN_W-1:0] DIM_SCALE = 8'd26;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STOP_COUNT     = 3'd0,
        REG_STOP_A         = 3'd1,
        REG_STOP_B         = 3'd2,
        REG_STOP_C         = 3'd3,
        REG_STOP_D         = 3'd4,
        REG_STOP_E         = 3'd5,
        REG_SEGMENT_LENGTH = 3'd6,
        REG_FADE_ENABLE    = 3'd7
    } cfg_reg_t;

    // index 2 red, 1 green, 0 blue
    typedef logic [2:0][CHAN_W-1:0] rgb_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        rgb_t             color;
    } stop_t;

    typedef struct packed {
        logic              scale_on;
        logic              dim_on;
        logic [CHAN_W-1:0] scale;
    } fade_t;

endpackage

`default_nettype wire

/* rtl/multi_stop_color_gradient_core.sv */
// multi-stop colour gradient core: 12 register stages, one pixel per cycle
// throughput: one transaction per cycle, limited by nothing but output stalls
// reset: pipeline valid bits clear; registers return to 0 stops, length 2, no fade
// depends on msg_pkg, msg_pos_div, msg_lerp, msg_fade
`default_nettype none

module multi_stop_color_gradient_core
    import msg_pkg::*;
#(
    parameter int MAX_SEGMENT = MAX_SEGMENT_DEF,
    parameter int NUM_STOPS   = NUM_STOPS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,   // pixel_offset[9:0], zero pad
    input  wire logic                  s_tlast,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [23:0]           m_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic                       m_tlast,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int LEN_W = $clog2(MAX_SEGMENT + 1);
    localparam int CW    = (LEN_W > LEN_REG_W) ? LEN_W : LEN_REG_W;

    // configuration registers
    logic [CNT_W-1:0]     stop_count_reg;
    stop_t                stop_reg [NUM_STOPS];
    logic [LEN_REG_W-1:0] seg_len_reg;
    logic                 fade_en_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_count_reg <= '0;
            seg_len_reg    <= LEN_REG_W'(2);
            fade_en_reg    <= 1'b0;
            for (int k = 0; k < NUM_STOPS; k++)
            begin
                stop_reg[k] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_STOP_COUNT:     stop_count_reg <= cfg_data[CNT_W-1:0];
                REG_SEGMENT_LENGTH: seg_len_reg    <= cfg_data[LEN_REG_W-1:0];
                REG_FADE_ENABLE:    fade_en_reg    <= cfg_data[0];
                default:
                begin
                    for (int k = 0; k < NUM_STOPS; k++)
                    begin
                        if (cfg_index == CFG_IDX_W'(REG_STOP_A) + CFG_IDX_W'(k))
                        begin
                            stop_reg[k] <= cfg_data;
                        end
                    end
                end
            endcase
        end
    end

    logic [CW-1:0]    len_x;
    logic [LEN_W-1:0] len_eff;
    logic [CNT_W-1:0] n_eff;

    always_comb
    begin
        len_x = CW'(seg_len_reg);
        if (len_x < CW'(2))
        begin
            len_x = CW'(2);
        end
        else if (len_x > CW'(MAX_SEGMENT))
        begin
            len_x = CW'(MAX_SEGMENT);
        end
        len_eff = LEN_W'(len_x);
    end

    assign n_eff = (stop_count_reg > CNT_W'(NUM_STOPS)) ? CNT_W'(NUM_STOPS) : stop_count_reg;

    // pipeline control
    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES:0]   en;
    logic                   last_reg [PIPE_STAGES];

    always_comb
    begin
        en[PIPE_STAGES] = m_tready;
        for (int k = PIPE_STAGES - 1; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < PIPE_STAGES; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    logic [OFF_W-1:0] off_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            last_reg[0] <= s_tlast;
            off_reg     <= s_tdata[OFF_W-1:0];
        end
        for (int k = 1; k < PIPE_STAGES; k++)
        begin
            if (en[k])
            begin
                last_reg[k] <= last_reg[k-1];
            end
        end
    end

    // datapath
    logic [POS_W-1:0] position;
    rgb_t             lerp_color;
    fade_t            fade;

    msg_pos_div #(
        .LEN_W (LEN_W)
    ) u_pos_div (
        .clk          (clk),
        .stage_en     (en[4:1]),
        .pixel_offset (off_reg),
        .divisor      (len_eff - LEN_W'(1)),
        .position     (position)
    );

    msg_lerp #(
        .NUM_STOPS (NUM_STOPS)
    ) u_lerp (
        .clk      (clk),
        .stage_en (en[9:5]),
        .position (position),
        .stops    (stop_reg),
        .n_eff    (n_eff),
        .color    (lerp_color)
    );

    msg_fade #(
        .MAX_SEGMENT (MAX_SEGMENT),
        .LEN_W       (LEN_W)
    ) u_fade (
        .clk          (clk),
        .stage_en     (en[9:1]),
        .pixel_offset (off_reg),
        .len_eff      (len_eff),
        .fade_on      (fade_en_reg),
        .fade         (fade)
    );

    function automatic logic [CHAN_W-1:0] video_scale(logic [CHAN_W-1:0] x,
                                                      logic [CHAN_W-1:0] s);
        logic [2*CHAN_W-1:0] prod;
        prod = (2*CHAN_W)'(x) * (2*CHAN_W)'(s);
        if (x == '0)
        begin
            return '0;
        end
        return prod[2*CHAN_W-1:CHAN_W] + CHAN_W'(s != '0);
    endfunction

    rgb_t scaled_reg;
    logic dim_reg;
    rgb_t out_reg;

    always_ff @(posedge clk)
    begin
        if (en[10])
        begin
            dim_reg <= fade.dim_on;
            for (int k = 0; k < 3; k++)
            begin
                scaled_reg[k] <= fade.scale_on ? video_scale(lerp_color[k], fade.scale)
                                               : lerp_color[k];
            end
        end
        if (en[11])
        begin
            for (int k = 0; k < 3; k++)
            begin
                out_reg[k] <= dim_reg ? video_scale(scaled_reg[k], DIM_SCALE) : scaled_reg[k];
            end
        end
    end

    assign m_tvalid = valid_reg[PIPE_STAGES-1];
    assign m_tdata  = {out_reg[0], out_reg[1], out_reg[2]};
    assign m_tlast  = last_reg[PIPE_STAGES-1];

    // any empty stage lets a new transaction in
    assert property (@(posedge clk) disable iff (!rst_n)
        !(&valid_reg) |-> s_tready)
        else $error("input stalled with an empty stage in the pipeline");

    // the first fade never scales below a tenth of full brightness
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[9] && fade.scale_on |-> fade.scale >= 8'd25)
        else $error("fade scale below its lower bound");

    // a taken result with nothing behind it leaves the output empty
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !valid_reg[PIPE_STAGES-2] |=> !m_tvalid)
        else $error("result repeated on the output");

endmodule

`default_nettype wire

/* rtl/msg_pos_div.sv */
// position divider: offset * 32768 / (length - 1), saturated to 16 bits
// four register stages of four restoring steps each; uses msg_pkg
`default_nettype none

module msg_pos_div
    import msg_pkg::*;
#(
    parameter int LEN_W = 11
)
(
    input  wire logic             clk,
    input  wire logic [3:0]       stage_en,
    input  wire logic [OFF_W-1:0] pixel_offset,
    input  wire logic [LEN_W-1:0] divisor,
    output logic      [POS_W-1:0] position
);

    localparam int STEPS = 4;
    localparam int NSTG  = POS_W / STEPS;
    localparam int CW    = (OFF_W > LEN_W + 1) ? OFF_W : LEN_W + 1;

    logic [LEN_W-1:0] rem_reg [NSTG];
    logic [POS_W-1:0] quo_reg [NSTG];
    logic             ovf_reg [NSTG];

    logic [LEN_W-1:0] start_rem;
    logic             ovf;

    assign start_rem = LEN_W'(pixel_offset >> 1);
    assign ovf       = CW'(pixel_offset) >= (CW'(divisor) << 1);

    for (genvar g = 0; g < NSTG; g++) begin : g_stage
        logic [LEN_W-1:0] rem_src;
        logic [POS_W-1:0] quo_src;
        logic             ovf_src;
        logic             first_bit;
        logic [LEN_W-1:0] rem_next;
        logic [POS_W-1:0] quo_next;

        if (g == 0) begin : g_first
            assign rem_src   = start_rem;
            assign quo_src   = '0;
            assign ovf_src   = ovf;
            assign first_bit = pixel_offset[0];
        end
        else begin : g_rest
            assign rem_src   = rem_reg[g-1];
            assign quo_src   = quo_reg[g-1];
            assign ovf_src   = ovf_reg[g-1];
            assign first_bit = 1'b0;
        end

        always_comb
        begin : steps
            logic [LEN_W:0]   t;
            logic [LEN_W-1:0] r;
            logic [POS_W-1:0] q;
            r = rem_src;
            q = quo_src;
            for (int j = 0; j < STEPS; j++)
            begin
                t = {r, (j == 0) ? first_bit : 1'b0};
                if (t >= {1'b0, divisor})
                begin
                    t = t - {1'b0, divisor};
                    q = {q[POS_W-2:0], 1'b1};
                end
                else
                begin
                    q = {q[POS_W-2:0], 1'b0};
                end
                r = t[LEN_W-1:0];
            end
            rem_next = r;
            quo_next = q;
        end

        always_ff @(posedge clk)
        begin
            if (stage_en[g])
            begin
                rem_reg[g] <= rem_next;
                quo_reg[g] <= quo_next;
                ovf_reg[g] <= ovf_src;
            end
        end
    end

    assign position = ovf_reg[NSTG-1] ? '1 : quo_reg[NSTG-1];

endmodule

`default_nettype wire

/* rtl/msg_lerp.sv */
// stop pair search and per-channel linear interpolation with floor
// stages: select, multiply, sum, two divide stages; uses msg_pkg
`default_nettype none

module msg_lerp
    import msg_pkg::*;
#(
    parameter int NUM_STOPS = NUM_STOPS_DEF
)
(
    input  wire logic             clk,
    input  wire logic [4:0]       stage_en,
    input  wire logic [POS_W-1:0] position,
    input  wire stop_t            stops [NUM_STOPS],
    input  wire logic [CNT_W-1:0] n_eff,
    output rgb_t                  color
);

    localparam int PW = 2 * CHAN_W + POS_W;
    localparam int NW = CHAN_W + POS_W;

    // select stage
    logic [POS_W-1:0] den_reg;
    logic [POS_W-1:0] num_reg;
    rgb_t             c1_reg;
    rgb_t             c2_reg;

    logic [POS_W-1:0] den_next;
    logic [POS_W-1:0] num_next;
    rgb_t             c1_next;
    rgb_t             c2_next;

    always_comb
    begin : select
        logic             found;
        logic [POS_W-1:0] plo;
        logic [POS_W-1:0] phi;
        rgb_t             clo;
        rgb_t             chi;
        found = 1'b0;
        plo   = stops[0].pos;
        phi   = stops[0].pos;
        clo   = stops[0].color;
        chi   = stops[0].color;
        for (int j = 0; j < NUM_STOPS - 1; j++)
        begin
            if (!found && (CNT_W'(j + 1) < n_eff) && (position >= stops[j].pos)
                && (position <= stops[j+1].pos))
            begin
                found = 1'b1;
                plo   = stops[j].pos;
                phi   = stops[j+1].pos;
                clo   = stops[j].color;
                chi   = stops[j+1].color;
            end
        end
        if (n_eff == '0)
        begin
            clo = '0;
            chi = '0;
        end
        den_next = phi - plo;
        num_next = position - plo;
        if (den_next == '0)
        begin
            den_next = POS_W'(1);
            num_next = '0;
        end
        c1_next = clo;
        c2_next = chi;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            den_reg <= den_next;
            num_reg <= num_next;
            c1_reg  <= c1_next;
            c2_reg  <= c2_next;
        end
    end

    // multiply, sum and divide stages
    logic [PW-1:0]    m1_reg  [3];
    logic [PW-1:0]    m2_reg  [3];
    logic [POS_W-1:0] den2_reg;
    logic [NW-1:0]    tot_reg [3];
    logic [POS_W-1:0] den3_reg;
    logic [POS_W-1:0] rem_reg [3];
    logic [3:0]       quo_reg [3];
    logic [3:0]       low_reg [3];
    logic [POS_W-1:0] den4_reg;
    rgb_t             color_reg;

    for (genvar k = 0; k < 3; k++) begin : g_chan
        logic [POS_W-1:0] rem_hi;
        logic [3:0]       quo_hi;
        logic [CHAN_W-1:0] quo_lo;

        always_comb
        begin : div_hi
            logic [POS_W:0]   t;
            logic [POS_W-1:0] r;
            logic [3:0]       q;
            r = tot_reg[k][NW-1:CHAN_W];
            q = '0;
            for (int j = 0; j < 4; j++)
            begin
                t = {r, tot_reg[k][CHAN_W-1-j]};
                if (t >= {1'b0, den3_reg})
                begin
                    t = t - {1'b0, den3_reg};
                    q = {q[2:0], 1'b1};
                end
                else
                begin
                    q = {q[2:0], 1'b0};
                end
                r = t[POS_W-1:0];
            end
            rem_hi = r;
            quo_hi = q;
        end

        always_comb
        begin : div_lo
            logic [POS_W:0]    t;
            logic [POS_W-1:0]  r;
            logic [CHAN_W-1:0] q;
            r = rem_reg[k];
            q = {4'b0, quo_reg[k]};
            for (int j = 0; j < 4; j++)
            begin
                t = {r, low_reg[k][3-j]};
                if (t >= {1'b0, den4_reg})
                begin
                    t = t - {1'b0, den4_reg};
                    q = {q[CHAN_W-2:0], 1'b1};
                end
                else
                begin
                    q = {q[CHAN_W-2:0], 1'b0};
                end
                r = t[POS_W-1:0];
            end
            quo_lo = q;
        end

        always_ff @(posedge clk)
        begin
            if (stage_en[1])
            begin
                m1_reg[k] <= PW'(c1_reg[k]) * PW'(den_reg - num_reg);
                m2_reg[k] <= PW'(c2_reg[k]) * PW'(num_reg);
            end
            if (stage_en[2])
            begin
                tot_reg[k] <= NW'(m1_reg[k] + m2_reg[k]);
            end
            if (stage_en[3])
            begin
                rem_reg[k] <= rem_hi;
                quo_reg[k] <= quo_hi;
                low_reg[k] <= tot_reg[k][3:0];
            end
            if (stage_en[4])
            begin
                color_reg[k] <= quo_lo;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            den2_reg <= den_reg;
        end
        if (stage_en[2])
        begin
            den3_reg <= den2_reg;
        end
        if (stage_en[3])
        begin
            den4_reg <= den3_reg;
        end
    end

    assign color = color_reg;

endmodule

`default_nettype wire

/* rtl/msg_fade.sv */
// top fade scale: floor(255 * (10 b^3 - 9 a^3) / (10 b^3)) and fade flags
// cube stages then a four-stage restoring divider; uses msg_pkg
`default_nettype none

module msg_fade
    import msg_pkg::*;
#(
    parameter int MAX_SEGMENT = MAX_SEGMENT_DEF,
    parameter int LEN_W       = 11
)
(
    input  wire logic             clk,
    input  wire logic [8:0]       stage_en,
    input  wire logic [OFF_W-1:0] pixel_offset,
    input  wire logic [LEN_W-1:0] len_eff,
    input  wire logic             fade_on,
    output fade_t                 fade
);

    localparam int BW   = $clog2(11 * MAX_SEGMENT + 1);
    localparam int TW   = ((BW > OFF_W + 5) ? BW : OFF_W + 5) + 1;
    localparam int DW   = 3 * BW + 4;
    localparam int NW   = DW + 8;
    localparam int NDIV = 4;

    // progress terms
    logic [TW-1:0] off_x;
    logic [TW-1:0] len_x;
    logic [TW-1:0] off20;
    logic [TW-1:0] off10;
    logic [TW-1:0] len9;
    logic [TW-1:0] len11;
    logic [TW-1:0] a_full;
    logic          above;
    logic          dim;

    assign off_x  = TW'(pixel_offset);
    assign len_x  = TW'(len_eff);
    assign off20  = (off_x << 4) + (off_x << 2);
    assign off10  = (off_x << 3) + (off_x << 1);
    assign len9   = (len_x << 3) + len_x;
    assign len11  = (len_x << 3) + (len_x << 1) + len_x;
    assign above  = off20 >= len9;
    assign dim    = off10 >= len9;
    assign a_full = (off20 - len9 > len11) ? len11 : off20 - len9;

    logic [1:0]      flag_reg [8];
    logic [BW-1:0]   a_reg;
    logic [BW-1:0]   b_reg;
    logic [BW-1:0]   a2v_reg;
    logic [2*BW-1:0] a_sq_reg;
    logic [2*BW-1:0] b_sq_reg;
    logic [BW-1:0]   b2v_reg;
    logic [3*BW-1:0] a_cu_reg;
    logic [3*BW-1:0] b_cu_reg;
    logic [NW-1:0]   n_reg;
    logic [DW-1:0]   d_reg;
    logic [DW-1:0]   d_pipe_reg [NDIV];
    logic [DW-1:0]   rem_reg    [NDIV];
    logic [7:0]      quo_reg    [NDIV];
    logic [7:0]      low_reg    [NDIV];
    fade_t           fade_reg;

    logic [DW-1:0] d_next;
    logic [DW-1:0] m_next;

    assign d_next = (DW'(b_cu_reg) << 3) + (DW'(b_cu_reg) << 1);
    assign m_next = d_next - ((DW'(a_cu_reg) << 3) + DW'(a_cu_reg));

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            flag_reg[0] <= {fade_on && above, fade_on && above && dim};
            a_reg       <= BW'(a_full);
            b_reg       <= BW'(len11);
        end
        if (stage_en[1])
        begin
            a_sq_reg <= (2*BW)'(a_reg) * (2*BW)'(a_reg);
            b_sq_reg <= (2*BW)'(b_reg) * (2*BW)'(b_reg);
            a2v_reg  <= a_reg;
            b2v_reg  <= b_reg;
        end
        if (stage_en[2])
        begin
            a_cu_reg <= (3*BW)'(a_sq_reg) * (3*BW)'(a2v_reg);
            b_cu_reg <= (3*BW)'(b_sq_reg) * (3*BW)'(b2v_reg);
        end
        if (stage_en[3])
        begin
            d_reg <= d_next;
            n_reg <= (NW'(m_next) << 8) - NW'(m_next);
        end
        if (stage_en[8])
        begin
            fade_reg.scale_on <= flag_reg[7][1];
            fade_reg.dim_on   <= flag_reg[7][0];
            fade_reg.scale    <= quo_reg[NDIV-1];
        end
    end

    for (genvar k = 1; k < 8; k++) begin : g_flag
        always_ff @(posedge clk)
        begin
            if (stage_en[k])
            begin
                flag_reg[k] <= flag_reg[k-1];
            end
        end
    end

    for (genvar g = 0; g < NDIV; g++) begin : g_div
        logic [DW-1:0] rem_src;
        logic [7:0]    quo_src;
        logic [7:0]    low_src;
        logic [DW-1:0] d_src;
        logic [DW-1:0] rem_next;
        logic [7:0]    quo_next;

        if (g == 0) begin : g_first
            assign rem_src = DW'(n_reg >> 8);
            assign quo_src = '0;
            assign low_src = n_reg[7:0];
            assign d_src   = d_reg;
        end
        else begin : g_rest
            assign rem_src = rem_reg[g-1];
            assign quo_src = quo_reg[g-1];
            assign low_src = low_reg[g-1];
            assign d_src   = d_pipe_reg[g-1];
        end

        always_comb
        begin : steps
            logic [DW:0]   t;
            logic [DW-1:0] r;
            logic [7:0]    q;
            r = rem_src;
            q = quo_src;
            for (int j = 0; j < 2; j++)
            begin
                t = {r, low_src[7 - 2*g - j]};
                if (t >= {1'b0, d_src})
                begin
                    t = t - {1'b0, d_src};
                    q = {q[6:0], 1'b1};
                end
                else
                begin
                    q = {q[6:0], 1'b0};
                end
                r = t[DW-1:0];
            end
            rem_next = r;
            quo_next = q;
        end

        always_ff @(posedge clk)
        begin
            if (stage_en[4 + g])
            begin
                rem_reg[g]    <= rem_next;
                quo_reg[g]    <= quo_next;
                low_reg[g]    <= low_src;
                d_pipe_reg[g] <= d_src;
            end
        end
    end

    assign fade = fade_reg;

endmodule

`default_nettype wire
